FILE: rtl/core/timestamp_text_to_milliseconds_defines.svh
// Assertion helpers for the timestamp parser RTL, used by tsms_back.
`ifndef TIMESTAMP_TEXT_TO_MILLISECONDS_DEFINES_SVH
`define TIMESTAMP_TEXT_TO_MILLISECONDS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsms: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsms: next-cycle check failed");

`endif

FILE: rtl/core/tsms_pkg.sv
`default_nettype none

package tsms_pkg;

    // Parser phase codes.
    localparam logic [3:0] PH_LEAD  = 4'd0;
    localparam logic [3:0] PH_HH1   = 4'd1;
    localparam logic [3:0] PH_MM1   = 4'd2;
    localparam logic [3:0] PH_SS1   = 4'd3;
    localparam logic [3:0] PH_MS1   = 4'd4;
    localparam logic [3:0] PH_TRAIL = 4'd5;
    localparam logic [3:0] PH_GAP   = 4'd6;
    localparam logic [3:0] PH_HH2   = 4'd7;
    localparam logic [3:0] PH_MM2   = 4'd8;
    localparam logic [3:0] PH_SS2   = 4'd9;
    localparam logic [3:0] PH_MS2   = 4'd10;

    // Character codes.
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;

    // Time constants.
    localparam int SEC_PER_MIN  = 60;
    localparam int MIN_PER_HOUR = 60;
    localparam int HOUR_PER_DAY = 24;
    localparam int MS_PER_SEC   = 1000;
    localparam int SEC_PER_HOUR = SEC_PER_MIN * MIN_PER_HOUR;
    localparam int MS_PER_DAY   = SEC_PER_HOUR * HOUR_PER_DAY * MS_PER_SEC;

    localparam int FIELD_W = 16;
    localparam int ACC_W   = 17;
    localparam int TOTAL_W = 43;

    // Accumulator saturation value, one above the largest legal field.
    localparam logic [ACC_W-1:0] ACC_SAT = 17'd65536;

    // Depth of the queue between parser and arithmetic.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One parsed timestamp handed from the parser to the arithmetic.
    typedef struct packed {
        logic               ok;
        logic               two_tokens;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic [FIELD_W-1:0] ms;
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/core/tsms_if.sv
`default_nettype none

// Character request channel.
interface tsms_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       is_last;

    modport source (output valid, output text_char, output is_last, input ready);
    modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

// Result request channel.
interface tsms_out_if;
    logic        valid;
    logic        ready;
    logic        parse_ok;
    logic [42:0] total_ms;

    modport source (output valid, output parse_ok, output total_ms, input ready);
    modport sink   (input valid, input parse_ok, input total_ms, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tsms_front.sv
`default_nettype none

module tsms_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_char_valid,
    output logic                o_char_ready,
    input  wire  [7:0]          i_text_char,
    input  wire                 i_is_last,
    output logic                o_job_valid,
    input  wire                 i_job_ready,
    output tsms_pkg::t_job      o_job
);
    import tsms_pkg::*;

    logic [3:0]         r_phase, n_phase;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [FIELD_W-1:0] r_day, n_day;
    logic [FIELD_W-1:0] r_hour, n_hour;
    logic [FIELD_W-1:0] r_min, n_min;
    logic [FIELD_W-1:0] r_sec, n_sec;
    logic [1:0]         r_cnt, n_cnt;
    logic               r_frac_bad, n_frac_bad;
    logic               r_failed, n_failed;

    logic       accept;
    logic       is_ws, is_digit, field_ok, skip;
    logic [3:0] ph;
    logic [7:0] sep;
    logic [3:0] to;
    t_job       job;

    function automatic logic [ACC_W-1:0] add_digit(input logic [ACC_W-1:0] acc,
                                                   input logic [7:0] c);
        logic [ACC_W+2:0] v;
        v = ({3'b000, acc} << 3) + ({3'b000, acc} << 1) + {16'd0, c[3:0]};
        return (v > {3'b000, ACC_SAT}) ? ACC_SAT : v[ACC_W-1:0];
    endfunction

    assign accept       = i_char_valid && o_char_ready;
    assign o_char_ready = i_job_ready;

    assign is_ws    = (i_text_char == CH_SPACE) ||
                      (i_text_char >= CH_TAB && i_text_char <= CH_CR);
    assign is_digit = (i_text_char >= CH_ZERO) && (i_text_char <= CH_NINE);
    assign field_ok = (r_cnt != 2'd0) && !r_acc[ACC_W-1];

    // One character of the parse.
    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_day      = r_day;
        n_hour     = r_hour;
        n_min      = r_min;
        n_sec      = r_sec;
        n_cnt      = r_cnt;
        n_frac_bad = r_frac_bad;
        n_failed   = r_failed;
        skip       = 1'b0;
        ph         = r_phase;
        sep        = CH_COLON;
        to         = PH_MM1;

        if ((ph == PH_LEAD) || (ph == PH_GAP)) begin
            if (is_ws) begin
                skip = 1'b1;
            end else begin
                ph = (ph == PH_LEAD) ? PH_HH1 : PH_HH2;
            end
        end

        unique case (ph) inside
            PH_HH1:  to = PH_MM1;
            PH_HH2:  to = PH_MM2;
            PH_MM1:  to = PH_SS1;
            PH_MM2:  to = PH_SS2;
            PH_SS1:  to = PH_MS1;
            PH_SS2:  to = PH_MS2;
            default: to = ph;
        endcase
        if ((ph == PH_SS1) || (ph == PH_SS2)) begin
            sep = CH_DOT;
        end

        if (!r_failed && !skip) begin
            n_phase = ph;
            unique case (ph) inside
                PH_HH1, PH_HH2, PH_MM1, PH_MM2, PH_SS1, PH_SS2: begin
                    if ((ph == PH_HH1) && is_ws) begin
                        // A first token ended by a space is the day count.
                        if ((i_text_char == CH_SPACE) && field_ok) begin
                            n_day   = r_acc[FIELD_W-1:0];
                            n_acc   = '0;
                            n_cnt   = 2'd0;
                            n_phase = PH_GAP;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end else if (is_digit) begin
                        n_acc = add_digit(r_acc, i_text_char);
                        n_cnt = (r_cnt == 2'd3) ? r_cnt : r_cnt + 2'd1;
                    end else if ((i_text_char == sep) && field_ok) begin
                        if ((ph == PH_HH1) || (ph == PH_HH2)) begin
                            n_hour = r_acc[FIELD_W-1:0];
                        end else if ((ph == PH_MM1) || (ph == PH_MM2)) begin
                            n_min = r_acc[FIELD_W-1:0];
                        end else begin
                            n_sec = r_acc[FIELD_W-1:0];
                        end
                        n_acc   = '0;
                        n_cnt   = 2'd0;
                        n_phase = to;
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_MS1, PH_MS2: begin
                    if (is_digit) begin
                        n_acc = add_digit(r_acc, i_text_char);
                        n_cnt = (r_cnt == 2'd3) ? r_cnt : r_cnt + 2'd1;
                    end else begin
                        n_frac_bad = 1'b1;
                        if ((ph == PH_MS1) && is_ws) begin
                            n_phase = PH_TRAIL;
                        end
                    end
                end
                PH_TRAIL: begin
                    if (!is_ws) begin
                        n_failed = 1'b1;
                    end
                end
                default: n_failed = 1'b1;
            endcase
        end
    end

    // End of text: decide success and scale the millisecond part.
    always_comb begin
        job            = '0;
        job.day        = n_day;
        job.hour       = n_hour;
        job.minute     = n_min;
        job.second     = n_sec;
        job.two_tokens = (n_phase >= PH_HH2);
        unique case (n_phase) inside
            PH_SS1, PH_SS2: begin
                job.ok     = !n_failed && (n_cnt != 2'd0) && !n_acc[ACC_W-1];
                job.second = n_acc[FIELD_W-1:0];
            end
            PH_MS1, PH_MS2, PH_TRAIL: begin
                job.ok = !n_failed;
                if (!n_frac_bad && (n_cnt != 2'd0) && !n_acc[ACC_W-1]) begin
                    if (n_cnt == 2'd1) begin
                        job.ms = {6'd0, {6'd0, n_acc[3:0]} * 10'd100};
                    end else if (n_cnt == 2'd2) begin
                        job.ms = {6'd0, {3'd0, n_acc[6:0]} * 10'd10};
                    end else begin
                        job.ms = n_acc[FIELD_W-1:0];
                    end
                end
            end
            default: job.ok = 1'b0;
        endcase
    end

    assign o_job_valid = accept && i_is_last;
    assign o_job       = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_is_last)) begin
            r_phase    <= PH_LEAD;
            r_acc      <= '0;
            r_day      <= '0;
            r_hour     <= '0;
            r_min      <= '0;
            r_sec      <= '0;
            r_cnt      <= 2'd0;
            r_frac_bad <= 1'b0;
            r_failed   <= 1'b0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_day      <= n_day;
            r_hour     <= n_hour;
            r_min      <= n_min;
            r_sec      <= n_sec;
            r_cnt      <= n_cnt;
            r_frac_bad <= n_frac_bad;
            r_failed   <= n_failed;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tsms_queue.sv
`default_nettype none

module tsms_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push_valid,
    output logic                o_push_ready,
    input  tsms_pkg::t_job      i_push_data,
    output logic                o_pop_valid,
    input  wire                 i_pop_ready,
    output tsms_pkg::t_job      o_pop_data
);
    import tsms_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              push, pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tsms_back.sv
`default_nettype none
`include "timestamp_text_to_milliseconds_defines.svh"

module tsms_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_wdata,
    input  wire                 i_job_valid,
    output logic                o_job_ready,
    input  tsms_pkg::t_job      i_job,
    output logic                o_res_valid,
    input  wire                 i_res_ready,
    output logic                o_parse_ok,
    output logic [42:0]         o_total_ms
);
    import tsms_pkg::*;

    logic r_limit;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en;

    logic [27:0]        r1_h, r2_secs;
    logic [21:0]        r1_m;
    logic [TOTAL_W-1:0] r1_dayms, r2_dayms, r3_dayms;
    logic [FIELD_W-1:0] r1_s, r1_ms, r2_ms, r3_ms;
    logic               r1_ok, r2_ok, r3_ok, r4_ok, r5_ok;
    logic [37:0]        r3_secms;
    logic [TOTAL_W-1:0] r4_t, r5_total;
    logic               n_ok;

    // The whole pipeline moves when the output register is free or drained.
    assign en          = !r_v5 || i_res_ready;
    assign o_job_ready = en;
    assign o_res_valid = r_v5;
    assign o_parse_ok  = r5_ok;
    assign o_total_ms  = r5_total;

    assign n_ok = r4_ok && !(r_limit && (r4_t[TOTAL_W-1:32] != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (en) begin
                r_v1 <= i_job_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Products of the hour, minute and day fields.
            r1_h     <= {12'd0, i_job.hour} * 28'(SEC_PER_HOUR);
            r1_m     <= {6'd0, i_job.minute} * 22'(SEC_PER_MIN);
            r1_dayms <= i_job.two_tokens ?
                        {27'd0, i_job.day} * TOTAL_W'(MS_PER_DAY) : '0;
            r1_s     <= i_job.second;
            r1_ms    <= i_job.ms;
            r1_ok    <= i_job.ok;
            // Seconds of the day part.
            r2_secs  <= r1_h + {6'd0, r1_m} + {12'd0, r1_s};
            r2_dayms <= r1_dayms;
            r2_ms    <= r1_ms;
            r2_ok    <= r1_ok;
            // Seconds to milliseconds.
            r3_secms <= {10'd0, r2_secs} * 38'(MS_PER_SEC);
            r3_dayms <= r2_dayms;
            r3_ms    <= r2_ms;
            r3_ok    <= r2_ok;
            // Total.
            r4_t     <= {5'd0, r3_secms} + {27'd0, r3_ms} + r3_dayms;
            r4_ok    <= r3_ok;
            // Limit check and result register.
            r5_ok    <= n_ok;
            r5_total <= n_ok ? r4_t : '0;
        end
    end

    `TSMS_ASSERT_SAME(a_fail_is_zero, i_clk, i_rst_n, r_v5 && !r5_ok, r5_total == '0)
    `TSMS_ASSERT_SAME(a_limit_kept, i_clk, i_rst_n, r_v5 && r5_ok && r_limit, r5_total[42:32] == '0)
    `TSMS_ASSERT_NEXT(a_stall_keeps_stage, i_clk, i_rst_n, r_v4 && !en, r_v4 && r_v5)

endmodule

`default_nettype wire

FILE: rtl/core/timestamp_text_to_milliseconds.sv
`default_nettype none
// Timestamp text parser. Characters of a text of the form [DD ]HH:MM:SS[.sss]
// arrive one per request on i_in (text_char, is_last). Leading whitespace is
// skipped. For the request that carries is_last, one result request leaves on
// o_out with parse_ok and total_ms (zero when the parse failed); no other
// character produces a result.
// Throughput is one character per cycle while the queue has room. The parser
// front end registers its field state as each character is accepted; a
// finished text goes into a two-entry queue and then through a five-stage
// arithmetic pipeline (field products, seconds sum, scaling to milliseconds,
// total, limit check), and o_out.valid rises when it reaches the last stage.
// When o_out stalls, the arithmetic pipeline holds and the queue fills; the
// parser keeps taking characters until the queue is full, then i_in.ready
// drops until the queue has room again.
// i_cfg_we writes i_cfg_wdata into the 32-bit limit mode bit, which makes any
// total above 4294967295 ms a failure. Write it only while no text is in
// flight. A synchronous active-low i_rst_n clears the parser, the queue, the
// pipeline valid bits and the mode bit; payload registers are not reset.
module timestamp_text_to_milliseconds (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    tsms_in_if.sink     i_in,
    tsms_out_if.source  o_out
);
    import tsms_pkg::*;

    logic front_valid, front_ready;
    t_job front_job;
    logic back_valid, back_ready;
    t_job back_job;

    // Front end: per-character parse and end-of-text decision.
    tsms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (i_in.valid),
        .o_char_ready (i_in.ready),
        .i_text_char  (i_in.text_char),
        .i_is_last    (i_in.is_last),
        .o_job_valid  (front_valid),
        .i_job_ready  (front_ready),
        .o_job        (front_job)
    );

    // Decouples the parser from stalls in the arithmetic.
    tsms_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_job),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_job)
    );

    // Back end: millisecond arithmetic and the output register.
    tsms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_job_valid  (back_valid),
        .o_job_ready  (back_ready),
        .i_job        (back_job),
        .o_res_valid  (o_out.valid),
        .i_res_ready  (o_out.ready),
        .o_parse_ok   (o_out.parse_ok),
        .o_total_ms   (o_out.total_ms)
    );

endmodule

`default_nettype wire

FILE: tb/sv/timestamp_text_to_milliseconds_tb.sv
module timestamp_text_to_milliseconds_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsms_pkg::*;

    // The run is far shorter than this. About 2200 characters go in. In one
    // mix the sender idles more than half the time, and in another the result
    // side stalls more than half the time; even so the slowest correct run
    // stays far below the limit.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int CHARS_PER_MIX = 500;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_PRINTED   = 40;

    typedef struct packed {
        bit               ok;
        bit [TOTAL_W-1:0] total;
    } t_timestamp_result;

    // The scoreboard tracks the parser. It follows every accepted character
    // with its own copy of the field state and holds the results that
    // finished texts should give, oldest first.
    class timestamp_scoreboard;
        bit                limit32;
        logic [3:0]        phase;
        bit [ACC_W-1:0]    acc;
        bit [FIELD_W-1:0]  day_v;
        bit [FIELD_W-1:0]  hour_v;
        bit [FIELD_W-1:0]  min_v;
        bit [FIELD_W-1:0]  sec_v;
        bit [1:0]          ndig;
        bit                frac_bad;
        bit                failed;
        t_timestamp_result expected_q[$];
        int                errors;

        function new();
            limit32 = 1'b0;
            errors  = 0;
            clear_fields();
        endfunction

        function void clear_fields();
            phase    = PH_LEAD;
            acc      = '0;
            day_v    = '0;
            hour_v   = '0;
            min_v    = '0;
            sec_v    = '0;
            ndig     = '0;
            frac_bad = 1'b0;
            failed   = 1'b0;
        endfunction

        function void set_limit(bit v);
            limit32 = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        function bit is_space(bit [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit is_num(bit [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        // The field value saturates one above the largest legal value, and
        // the digit count stops at three.
        function void push_digit(bit [7:0] c);
            bit [31:0] v;
            v   = 32'(acc) * 32'd10 + 32'(c) - 32'(CH_ZERO);
            acc = (v > 32'(ACC_SAT)) ? ACC_SAT : v[ACC_W-1:0];
            if (ndig < 2'd3)
                ndig++;
        endfunction

        function bit field_good();
            return ndig != 2'd0 && acc <= ACC_W'(65535);
        endfunction

        function void open_field(logic [3:0] to);
            acc   = '0;
            ndig  = '0;
            phase = to;
        endfunction

        // Returns 1 when the separator closes a legal field. The caller
        // stores the value and moves on.
        function bit field_char(bit [7:0] c, bit [7:0] sep);
            if (is_num(c)) begin
                push_digit(c);
                return 1'b0;
            end
            if (c == sep && field_good())
                return 1'b1;
            failed = 1'b1;
            return 1'b0;
        endfunction

        function void take_char(bit [7:0] c);
            if (failed)
                return;
            if (phase == PH_LEAD || phase == PH_GAP) begin
                if (is_space(c))
                    return;
                phase = (phase == PH_LEAD) ? PH_HH1 : PH_HH2;
            end
            case (phase)
                PH_HH1: begin
                    // A first token that ends in a plain space is a day count.
                    if (is_space(c)) begin
                        if (c == CH_SPACE && field_good()) begin
                            day_v = acc[FIELD_W-1:0];
                            open_field(PH_GAP);
                        end else begin
                            failed = 1'b1;
                        end
                    end else if (field_char(c, CH_COLON)) begin
                        hour_v = acc[FIELD_W-1:0];
                        open_field(PH_MM1);
                    end
                end
                PH_HH2: begin
                    if (field_char(c, CH_COLON)) begin
                        hour_v = acc[FIELD_W-1:0];
                        open_field(PH_MM2);
                    end
                end
                PH_MM1, PH_MM2: begin
                    if (field_char(c, CH_COLON)) begin
                        min_v = acc[FIELD_W-1:0];
                        open_field(phase == PH_MM1 ? PH_SS1 : PH_SS2);
                    end
                end
                PH_SS1, PH_SS2: begin
                    if (field_char(c, CH_DOT)) begin
                        sec_v = acc[FIELD_W-1:0];
                        open_field(phase == PH_SS1 ? PH_MS1 : PH_MS2);
                    end
                end
                PH_MS1, PH_MS2: begin
                    if (is_num(c)) begin
                        push_digit(c);
                    end else begin
                        frac_bad = 1'b1;
                        if (phase == PH_MS1 && is_space(c))
                            phase = PH_TRAIL;
                    end
                end
                PH_TRAIL: begin
                    if (!is_space(c))
                        failed = 1'b1;
                end
                default: begin
                    failed = 1'b1;
                end
            endcase
        endfunction

        function t_timestamp_result close_text();
            t_timestamp_result r;
            bit [63:0]         ms;
            bit [63:0]         t;
            bit                two;
            two = phase >= PH_HH2;
            r   = '0;
            ms  = '0;
            r.ok = !failed;
            if (failed) begin
                r.ok = 1'b0;
            end else if (phase == PH_SS1 || phase == PH_SS2) begin
                if (field_good())
                    sec_v = acc[FIELD_W-1:0];
                else
                    r.ok = 1'b0;
            end else if (phase == PH_MS1 || phase == PH_MS2 || phase == PH_TRAIL) begin
                // A bad millisecond part counts as zero; only short values
                // are scaled by their digit count.
                if (!frac_bad && field_good()) begin
                    ms = 64'(acc);
                    if (ms < 64'd1000) begin
                        if (ndig == 2'd1)
                            ms = ms * 64'd100;
                        else if (ndig == 2'd2)
                            ms = ms * 64'd10;
                    end
                end
            end else begin
                r.ok = 1'b0;
            end
            if (r.ok) begin
                t = (64'(sec_v) + 64'(min_v) * 64'd60 + 64'(hour_v) * 64'd3600) * 64'd1000
                    + ms;
                if (two)
                    t = t + 64'(day_v) * 64'd86400000;
                if (limit32 && t > 64'h0000_0000_FFFF_FFFF)
                    r.ok = 1'b0;
                else
                    r.total = t[TOTAL_W-1:0];
            end
            return r;
        endfunction

        // Called for every accepted character request.
        function void note_char(bit [7:0] c, bit last);
            take_char(c);
            if (last) begin
                expected_q.push_back(close_text());
                clear_fields();
            end
        endfunction

        // Called for every accepted result request.
        task check_result(bit ok, bit [TOTAL_W-1:0] total);
            t_timestamp_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result ok=%0b total=%0d with no text pending", ok, total));
                return;
            end
            want = expected_q.pop_front();
            if (ok != want.ok)
                report($sformatf("parse_ok %0b, expected %0b", ok, want.ok));
            if (total != want.total)
                report($sformatf("total_ms %0d, expected %0d", total, want.total));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    tsms_in_if  in_if();
    tsms_out_if out_if();

    timestamp_text_to_milliseconds i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    timestamp_scoreboard sb = new();

    // Characters of the text that is about to be sent.
    bit [7:0] text_buf[$];

    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int chars_in_mix    = 0;
    int cycle_count     = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // The watchdog. A correct run never gets near the limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timestamp_text_to_milliseconds_tb NOT OK");
            $finish;
        end
    end

    // The result side stalls at random, at the rate of the current mix.
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Values are read right at the edge, before any register of this edge
    // has been updated, so they are the ones that took part in the handshake.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.parse_ok, out_if.total_ms);
    end

    // Sends one character request. The sender may idle first. valid is left
    // high after the handshake, so the caller must either send the next
    // character in the same step or drop valid before it waits.
    task automatic send_char(input bit [7:0] c, input bit last);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.text_char <= c;
        in_if.is_last   <= last;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        sb.note_char(c, last);
        chars_in_mix++;
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    // Waits until every finished text has given its result.
    task automatic drain();
        while (sb.pending() != 0) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // The mode bit is written only while no text is in flight. A text that is
    // only partly sent never exists here, since every mix ends on a last
    // character, so draining and a short settle are enough.
    task automatic write_limit(input bit v);
        drain();
        repeat (SETTLE_CYCLES) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_limit(v);
    endtask

    function automatic void add_str(string s);
        foreach (s[i])
            text_buf.push_back(s[i]);
    endfunction

    // Appends v in decimal, padded with leading zeros to at least width digits.
    function automatic void add_value(int unsigned v, int unsigned width);
        bit [7:0] rev[$];
        do begin
            rev.push_back(8'(CH_ZERO + v % 10));
            v = v / 10;
        end while (v != 0);
        while (rev.size() < width)
            rev.push_back(CH_ZERO);
        while (rev.size() != 0)
            text_buf.push_back(rev.pop_back());
    endfunction

    // One numeric field. Most are clock-like; some sit at the largest legal
    // value or one above it, some are long enough to saturate, and some
    // carry leading zeros.
    function automatic void add_field();
        case ($urandom_range(9))
            0: add_value($urandom_range(9), 1);
            1, 2, 3, 4, 5: add_value($urandom_range(59), 2);
            6: add_value($urandom_range(65535), 1);
            7: add_value(65535 + $urandom_range(1), 1);
            8: repeat ($urandom_range(9, 6)) add_value($urandom_range(9), 1);
            default: begin
                add_value(0, $urandom_range(4, 2));
                add_value($urandom_range(99), 2);
            end
        endcase
    endfunction

    function automatic bit [7:0] ws_char();
        if ($urandom_range(1))
            return CH_SPACE;
        return 8'($urandom_range(CH_CR, CH_TAB));
    endfunction

    // Builds one random text. Most are well formed with random fields; a
    // share gets one character replaced, dropped, inserted or the tail cut,
    // and a few are plain noise.
    function automatic void make_text();
        int unsigned kind;
        int unsigned pos;
        string       alphabet;
        alphabet = "0123456789:. ";
        text_buf.delete();
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(12, 1)) begin
                if ($urandom_range(1))
                    text_buf.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
                else
                    text_buf.push_back(8'($urandom_range(255)));
            end
        end else begin
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(2, 1)) text_buf.push_back(ws_char());
            if ($urandom_range(3) == 0) begin
                add_field();
                text_buf.push_back($urandom_range(7) == 0 ? ws_char() : CH_SPACE);
                repeat ($urandom_range(2)) text_buf.push_back(ws_char());
            end
            add_field();
            text_buf.push_back(CH_COLON);
            add_field();
            text_buf.push_back(CH_COLON);
            add_field();
            if ($urandom_range(2) != 0) begin
                text_buf.push_back(CH_DOT);
                if ($urandom_range(5) == 0)
                    add_field();
                else
                    repeat ($urandom_range(4)) add_value($urandom_range(9), 1);
                if ($urandom_range(7) == 0)
                    text_buf.push_back(ws_char());
            end
            if (kind < 30) begin
                pos = $urandom_range(text_buf.size() - 1);
                case ($urandom_range(3))
                    0: text_buf[pos] = 8'($urandom_range(255));
                    1: text_buf.delete(pos);
                    2: text_buf.insert(pos, 8'($urandom_range(255)));
                    default: text_buf = text_buf[0:pos];
                endcase
            end
        end
        if (text_buf.size() == 0)
            text_buf.push_back(ws_char());
    endfunction

    // A directed text: head, then one raw character if mid is not negative,
    // then tail.
    task automatic run_text(input string head, input int mid = -1, input string tail = "");
        text_buf.delete();
        add_str(head);
        if (mid >= 0)
            text_buf.push_back(8'(mid));
        add_str(tail);
        send_text();
    endtask

    initial begin
        bit paused;

        in_if.valid     <= 1'b0;
        in_if.text_char <= '0;
        in_if.is_last   <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= 1'b0;
        i_rst_n         <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed texts, with neither side idling.
        write_limit(1'b0);
        run_text("00:00:00");
        run_text("  12:34:56.789");
        run_text("", CH_TAB, "1:2:3.4");
        run_text("1:2:3.45");
        run_text("1:2:3.0001234");
        run_text("10 65535:65535:65535.65535");
        run_text("65535 0:0:0");
        run_text("0:0:65536");
        run_text("9999999:0:0");
        run_text("1:2:3.65536");
        run_text("1:2:3.");
        run_text("1:2:3.1x");
        run_text("1:2:3.", 8'hFF);
        run_text("1:2:3.5 ", CH_TAB);
        run_text("2 1:2:3.4 7");
        run_text("1:2:3 ");
        run_text("5", CH_TAB, "1:2:3");
        run_text("5  ", CH_TAB, "1:2:3");
        run_text("+1:2:3");
        run_text(":1:2");
        run_text("12:34");
        run_text("1:2:3", 0);
        run_text("   ");
        // With the 32-bit mode on, 49 days 17:02:47.295 is the largest total
        // that still passes, and one millisecond more fails.
        write_limit(1'b1);
        run_text("49 17:02:47.295");
        run_text("49 17:02:47.296");
        run_text("1:2:3.", 8'h80);

        // Random texts in four mixes of idling, with the mode bit toggled
        // between mixes. Halfway through each mix the sender holds off until
        // every result is back.
        for (int mix = 0; mix < 4; mix++) begin
            write_limit(mix % 2 == 1);
            case (mix)
                0: begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 56;
                    sink_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    sink_stall_pct  = 56;
                end
                default: begin
                    sender_idle_pct = 16;
                    sink_stall_pct  = 16;
                end
            endcase
            chars_in_mix = 0;
            paused = 1'b0;
            while (chars_in_mix < CHARS_PER_MIX) begin
                if (!paused && chars_in_mix >= CHARS_PER_MIX / 2) begin
                    drain();
                    paused = 1'b1;
                end
                make_text();
                send_text();
            end
        end

        // Let the pipeline empty, then give any stray result time to show up.
        drain();
        repeat (SETTLE_CYCLES * 2) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("timestamp_text_to_milliseconds_tb OK");
        end else begin
            $display("timestamp_text_to_milliseconds_tb NOT OK");
        end
        $finish;
    end
endmodule
